### sv/lspf_pkg.sv
// ----------------------------------------------------------------------------
// Length/sequence packet framer package
// Shared types and constants for the framer core and the result serializer.
// ----------------------------------------------------------------------------
package lspf_pkg;

	// field widths
	localparam int LenW     = 32;
	localparam int ChunkW   = 24;
	localparam int ByteW    = 8;
	localparam int SeqW     = 8;

	// one input item yields at most this many result bytes
	localparam int MaxRes   = 5;
	localparam int IdxW     = $clog2(MaxRes);
	localparam int CntW     = $clog2(MaxRes + 1);

	// stream widths
	localparam int InDataW  = 40;	// msg_length, payload_byte
	localparam int InUserW  = 2;	// req_type
	localparam int OutDataW = 16;	// out_byte, message_end, error, zero pad
	localparam int OutUserW = 1;	// is_header

	localparam logic [ChunkW-1:0] MaxChunkRst = {ChunkW{1'b1}};

	// request kinds
	typedef enum logic [InUserW-1:0] {
		ReqBegin   = 2'd0,
		ReqPayload = 2'd1,
		ReqRestart = 2'd2
	} req_type_t;

	// one result byte with its flags
	typedef struct packed {
		logic [ByteW-1:0] out_byte;
		logic             is_header;
		logic             message_end;
		logic             run_last;
		logic             error;
	} res_t;

	// batch handed from the core to the serializer
	typedef struct packed {
		logic [CntW-1:0]         count;
		res_t [MaxRes-1:0]       batch;
	} load_t;

endpackage

### sv/lspf_out_ser.sv
// ----------------------------------------------------------------------------
// Result serializer
// Holds a transaction's result batch; sends one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module lspf_out_ser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load_valid,
	input  lspf_pkg::load_t                   load,
	output logic                              load_ready,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lspf_pkg::OutDataW-1:0]     m_tdata,	// out_byte, message_end, error
	output logic [lspf_pkg::OutUserW-1:0]     m_tuser,	// is_header
	output logic                              m_tlast
);
	import lspf_pkg::*;

	res_t [MaxRes-1:0] batch_q;
	logic [CntW-1:0]   cnt_q;
	logic [IdxW-1:0]   idx_q;
	logic              busy;
	logic              at_last;
	res_t              cur;

	assign busy    = (cnt_q != '0);
	assign at_last = (CntW'(idx_q) == cnt_q - CntW'(1));
	assign cur     = batch_q[idx_q];

	// free when empty or when the final byte leaves this cycle
	assign load_ready = !busy || (m_tready && at_last);

	assign m_tvalid = busy;
	assign m_tdata  = {{(OutDataW-ByteW-2){1'b0}}, cur.error, cur.message_end, cur.out_byte};
	assign m_tuser  = cur.is_header;
	assign m_tlast  = cur.run_last;

	// batch payload, no reset needed
	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			batch_q <= load.batch;
		end
	end

	// count and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load_valid && load_ready) begin
			cnt_q <= load.count;
			idx_q <= '0;
		end else if (busy && m_tready) begin
			if (at_last) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + IdxW'(1);
			end
		end
	end

endmodule

### sv/length_sequence_packet_framer.sv
// ----------------------------------------------------------------------------
// Length/sequence packet framer
// Splits message bodies into chunks, each led by a 3-byte length and 1-byte
// sequence id header.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    tdata: msg_length, payload_byte; tuser: req_type
//   m_*      out  m_tvalid/m_tready    tdata: out_byte, message_end, error;
//                                      tuser: is_header; tlast: run_last
//   cfg_*    in   cfg_valid/cfg_ready  cfg_data: max_chunk_len
//
// A transaction is decoded and its state updated in the accepting cycle; its
// result bytes (0 to 5) go out of the serializer batch one per cycle unless
// m_tready stalls them. A payload byte alone gives one byte; a header adds four.
// The next transaction is taken in the cycle the last byte of the batch leaves.
// Reset is asynchronous; the block is ready right after reset.
// ----------------------------------------------------------------------------
module length_sequence_packet_framer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lspf_pkg::InDataW-1:0]      s_tdata,	// msg_length, payload_byte
	input  logic [lspf_pkg::InUserW-1:0]      s_tuser,	// req_type
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lspf_pkg::OutDataW-1:0]     m_tdata,	// out_byte, message_end, error, pad
	output logic [lspf_pkg::OutUserW-1:0]     m_tuser,	// is_header
	output logic                              m_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lspf_pkg::ChunkW-1:0]       cfg_data	// max_chunk_len
);
	import lspf_pkg::*;

	// state
	logic [ChunkW-1:0] max_chunk_q;
	logic [SeqW-1:0]   seq_q;
	logic              restart_q;
	logic [LenW-1:0]   rem_q;
	logic [ChunkW-1:0] chunk_left_q;
	logic              was_full_q;
	logic              in_msg_q;

	// next state
	logic [SeqW-1:0]   seq_d;
	logic              restart_d;
	logic [LenW-1:0]   rem_d;
	logic [ChunkW-1:0] chunk_left_d;
	logic              was_full_d;
	logic              in_msg_d;

	logic              accept;
	logic [LenW-1:0]   msg_length;
	logic [ByteW-1:0]  payload_byte;
	logic [ChunkW-1:0] eff_max;
	logic [LenW-1:0]   rem_dec;
	logic [ChunkW-1:0] chunk_dec;
	logic [LenW-1:0]   chunk_src;
	logic [ChunkW-1:0] new_len;
	logic              new_full;
	logic [SeqW-1:0]   next_seq;

	// batch building
	logic              want_err;
	logic              want_pay;
	logic              want_hdr;
	logic              pay_end;
	logic              hdr_end;
	logic [ChunkW-1:0] hdr_len;
	load_t             load;
	logic              load_ready;

	assign cfg_ready    = 1'b1;
	assign s_tready     = load_ready;
	assign accept       = s_tvalid && s_tready;
	assign msg_length   = s_tdata[LenW-1:0];
	assign payload_byte = s_tdata[LenW +: ByteW];

	// chunk sizing, zero register reads as one
	assign eff_max   = (max_chunk_q == '0) ? ChunkW'(1) : max_chunk_q;
	assign rem_dec   = rem_q - LenW'(1);
	assign chunk_dec = chunk_left_q - ChunkW'(1);
	assign chunk_src = (s_tuser == ReqBegin) ? msg_length : rem_dec;
	assign new_full  = (chunk_src >= {{(LenW-ChunkW){1'b0}}, eff_max});
	assign new_len   = new_full ? eff_max : chunk_src[ChunkW-1:0];
	assign next_seq  = restart_q ? '0 : seq_q + SeqW'(1);

	// request decode and state update
	always_comb begin
		seq_d        = seq_q;
		restart_d    = restart_q;
		rem_d        = rem_q;
		chunk_left_d = chunk_left_q;
		was_full_d   = was_full_q;
		in_msg_d     = in_msg_q;
		want_err     = 1'b0;
		want_pay     = 1'b0;
		want_hdr     = 1'b0;
		pay_end      = 1'b0;
		hdr_end      = 1'b0;
		hdr_len      = '0;
		unique case (s_tuser)
			ReqRestart: begin
				restart_d = 1'b1;
			end
			ReqBegin: begin
				if (in_msg_q) begin
					want_err = 1'b1;
				end else begin
					rem_d        = msg_length;
					chunk_left_d = new_len;
					want_hdr     = 1'b1;
					hdr_len      = new_len;
					if (msg_length == '0) begin
						was_full_d = 1'b0;
						hdr_end    = 1'b1;
					end else begin
						was_full_d = new_full;
						in_msg_d   = 1'b1;
					end
				end
			end
			ReqPayload: begin
				if (!in_msg_q) begin
					want_err = 1'b1;
				end else begin
					want_pay     = 1'b1;
					rem_d        = rem_dec;
					chunk_left_d = chunk_dec;
					if (rem_dec == '0) begin
						in_msg_d     = 1'b0;
						chunk_left_d = '0;
						if (was_full_q) begin
							// closing empty chunk after an exactly full one
							was_full_d = 1'b0;
							want_hdr   = 1'b1;
							hdr_end    = 1'b1;
						end else begin
							pay_end = 1'b1;
						end
					end else if (chunk_dec == '0) begin
						chunk_left_d = new_len;
						was_full_d   = new_full;
						want_hdr     = 1'b1;
						hdr_len      = new_len;
					end
				end
			end
			default: begin
				want_err = 1'b1;
			end
		endcase
		if (want_hdr) begin
			seq_d     = next_seq;
			restart_d = 1'b0;
		end
	end

	// result batch: lone error byte, or optional payload byte then optional 4-byte header
	always_comb begin
		load.batch = '0;
		load.count = '0;
		if (want_err) begin
			load.batch[0].run_last = 1'b1;
			load.batch[0].error    = 1'b1;
			load.count             = CntW'(1);
		end else begin
			if (want_pay) begin
				load.batch[0].out_byte    = payload_byte;
				load.batch[0].message_end = pay_end;
				load.batch[0].run_last    = !want_hdr;
			end
			if (want_hdr) begin
				for (int i = 0; i < 4; i++) begin
					load.batch[i + (want_pay ? 1 : 0)].is_header = 1'b1;
				end
				load.batch[want_pay ? 1 : 0].out_byte = hdr_len[7:0];
				load.batch[want_pay ? 2 : 1].out_byte = hdr_len[15:8];
				load.batch[want_pay ? 3 : 2].out_byte = hdr_len[23:16];
				load.batch[want_pay ? 4 : 3].out_byte    = next_seq;
				load.batch[want_pay ? 4 : 3].message_end = hdr_end;
				load.batch[want_pay ? 4 : 3].run_last    = 1'b1;
			end
			load.count = CntW'((want_pay ? 1 : 0) + (want_hdr ? 4 : 0));
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chunk_q  <= MaxChunkRst;
			seq_q        <= '0;
			restart_q    <= 1'b1;
			rem_q        <= '0;
			chunk_left_q <= '0;
			was_full_q   <= 1'b0;
			in_msg_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_chunk_q <= cfg_data;
			end
			if (accept) begin
				seq_q        <= seq_d;
				restart_q    <= restart_d;
				rem_q        <= rem_d;
				chunk_left_q <= chunk_left_d;
				was_full_q   <= was_full_d;
				in_msg_q     <= in_msg_d;
			end
		end
	end

	lspf_out_ser u_out_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (accept),
		.load       (load),
		.load_ready (load_ready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

### tb/length_sequence_packet_framer_tb.sv
// ----------------------------------------------------------------------------
// Length/sequence packet framer testbench
// Drives begin, payload and restart transactions through the framer and
// predicts every output byte: 3-byte chunk lengths, sequence ids, payload
// pass-through, empty closing headers and error bytes. Starts with a stimulus
// table, then runs randomized messages under several chunk limits, with
// random idle bursts on both streams and one long output stall.
// ----------------------------------------------------------------------------
module length_sequence_packet_framer_tb;
	import lspf_pkg::*;

	// req_type code with no defined meaning
	localparam logic [1:0] ReqUndef = 2'd3;

	localparam int WatchdogLimit = 3000;
	localparam int HoldCycles    = 300;
	localparam int SettleCycles  = 8;
	localparam int DrainCycles   = 10;
	localparam int PhaseItems    = 55;
	localparam int NumPhases     = 6;
	localparam int NumDirected   = 22;

	localparam res_t ErrRes = '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1};
	localparam res_t NoRes  = '0;

	// one table row: either a register write (value in mlen) or a transaction,
	// optionally with its last output byte typed in
	typedef struct packed {
		logic             cfg;
		logic [1:0]       req;
		logic [31:0]      mlen;
		logic [7:0]       pb;
		logic             chk;
		res_t             last;
	} stim_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [InDataW-1:0]    s_tdata   = '0;	// msg_length, payload_byte
	logic [InUserW-1:0]    s_tuser   = '0;	// req_type
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OutDataW-1:0]   m_tdata;	// out_byte, message_end, error, pad
	logic [OutUserW-1:0]   m_tuser;	// is_header
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [ChunkW-1:0]     cfg_data  = '0;

	// framing state of the predictor
	logic [23:0] chunk_max   = 24'hFFFFFF;
	logic [7:0]  seq_id      = 8'd0;
	logic        seq_restart = 1'b1;
	logic [31:0] body_left   = 32'd0;
	logic [23:0] chunk_left  = 24'd0;
	logic        chunk_full  = 1'b0;
	logic        in_msg      = 1'b0;

	res_t framed_q[$];
	res_t want;
	int   fails       = 0;
	int   item_cnt    = 0;
	int   stall_cycles = 0;
	bit   quiet       = 1'b0;
	bit   hold_req    = 1'b0;

	stim_t directed_tab [NumDirected] = '{
		'{1'b0, ReqPayload, 32'd0,        8'h5a, 1'b1, ErrRes},
		'{1'b0, ReqUndef,   32'd0,        8'h00, 1'b1, ErrRes},
		'{1'b0, ReqBegin,   32'd0,        8'h00, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0}},
		'{1'b0, ReqBegin,   32'd0,        8'h00, 1'b1, '{8'h01, 1'b1, 1'b1, 1'b1, 1'b0}},
		'{1'b0, ReqRestart, 32'd0,        8'h00, 1'b0, NoRes},
		'{1'b0, ReqBegin,   32'd3,        8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1, 1'b0}},
		'{1'b0, ReqBegin,   32'd5,        8'h00, 1'b1, ErrRes},
		'{1'b0, ReqPayload, 32'd0,        8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0}},
		'{1'b0, ReqRestart, 32'd0,        8'h00, 1'b0, NoRes},
		'{1'b0, ReqPayload, 32'd0,        8'hff, 1'b1, '{8'hff, 1'b0, 1'b0, 1'b1, 1'b0}},
		'{1'b0, ReqUndef,   32'hFFFFFFFF, 8'hff, 1'b1, ErrRes},
		'{1'b0, ReqPayload, 32'd0,        8'ha5, 1'b1, '{8'ha5, 1'b0, 1'b1, 1'b1, 1'b0}},
		'{1'b0, ReqBegin,   32'd1,        8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1, 1'b0}},
		'{1'b0, ReqPayload, 32'd0,        8'h3c, 1'b1, '{8'h3c, 1'b0, 1'b1, 1'b1, 1'b0}},
		'{1'b0, ReqRestart, 32'd0,        8'h00, 1'b0, NoRes},
		'{1'b0, ReqPayload, 32'd0,        8'h11, 1'b1, ErrRes},
		// chunk limit 0 behaves as 1
		'{1'b1, ReqBegin,   32'd0,        8'h00, 1'b0, NoRes},
		'{1'b0, ReqBegin,   32'd2,        8'h00, 1'b0, NoRes},
		'{1'b0, ReqPayload, 32'd0,        8'h01, 1'b0, NoRes},
		// limit raised mid-message: the open full chunk still closes with an empty header
		'{1'b1, ReqBegin,   32'd3,        8'h00, 1'b0, NoRes},
		'{1'b0, ReqPayload, 32'd0,        8'h02, 1'b0, NoRes},
		'{1'b1, ReqBegin,   32'h00FFFFFF, 8'h00, 1'b0, NoRes}
	};

	length_sequence_packet_framer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic void push_res(input logic [7:0] b, input logic hdr, input logic endm,
			input logic last, input logic err);
		framed_q.push_back(res_t'{b, hdr, endm, last, err});
	endfunction

	// 4-byte header: length LSB first, then the sequence id
	function automatic void push_header(input logic [23:0] len, input logic endm);
		if (seq_restart) begin
			seq_restart = 1'b0;
			seq_id      = 8'd0;
		end else begin
			seq_id = seq_id + 8'd1;
		end
		push_res(len[7:0], 1'b1, 1'b0, 1'b0, 1'b0);
		push_res(len[15:8], 1'b1, 1'b0, 1'b0, 1'b0);
		push_res(len[23:16], 1'b1, 1'b0, 1'b0, 1'b0);
		push_res(seq_id, 1'b1, endm, 1'b1, 1'b0);
	endfunction

	// new chunk sized from what is left of the body
	function automatic logic [23:0] open_chunk();
		logic [23:0] eff;
		logic [23:0] len;
		eff        = (chunk_max == 24'd0) ? 24'd1 : chunk_max;
		len        = (body_left < {8'd0, eff}) ? body_left[23:0] : eff;
		chunk_left = len;
		chunk_full = (len == eff);
		return len;
	endfunction

	function automatic void frame_item(input logic [1:0] req, input logic [31:0] mlen,
			input logic [7:0] pb);
		logic [23:0] len;
		case (req)
			ReqRestart: begin
				seq_restart = 1'b1;
			end
			ReqBegin: begin
				if (in_msg) begin
					framed_q.push_back(ErrRes);
				end else begin
					body_left = mlen;
					len = open_chunk();
					if (mlen == 32'd0) begin
						chunk_full = 1'b0;
						push_header(24'd0, 1'b1);
					end else begin
						in_msg = 1'b1;
						push_header(len, 1'b0);
					end
				end
			end
			ReqPayload: begin
				if (!in_msg) begin
					framed_q.push_back(ErrRes);
				end else begin
					body_left  = body_left - 32'd1;
					chunk_left = chunk_left - 24'd1;
					if (body_left == 32'd0) begin
						in_msg     = 1'b0;
						chunk_left = 24'd0;
						if (chunk_full) begin
							// last chunk exactly full: empty header closes the message
							chunk_full = 1'b0;
							push_res(pb, 1'b0, 1'b0, 1'b0, 1'b0);
							push_header(24'd0, 1'b1);
						end else begin
							push_res(pb, 1'b0, 1'b1, 1'b1, 1'b0);
						end
					end else if (chunk_left == 24'd0) begin
						len = open_chunk();
						push_res(pb, 1'b0, 1'b0, 1'b0, 1'b0);
						push_header(len, 1'b0);
					end else begin
						push_res(pb, 1'b0, 1'b0, 1'b1, 1'b0);
					end
				end
			end
			default: begin
				framed_q.push_back(ErrRes);
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------
	task automatic run_item(input logic [1:0] req, input logic [31:0] mlen, input logic [7:0] pb);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {pb, mlen};
		do @(posedge clk); while (!s_tready);
		frame_item(req, mlen, pb);
		item_cnt++;
	endtask

	// register write once the block has drained
	task automatic write_chunk_limit(input logic [23:0] value);
		s_tvalid <= 1'b0;
		while (framed_q.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		chunk_max = value;
	endtask

	// well-formed message with occasional stray transactions inside
	task automatic send_message(input logic [31:0] len);
		run_item(ReqBegin, len, 8'($urandom));
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 11) == 0) begin
				case ($urandom_range(0, 2))
					0: run_item(ReqBegin, $urandom, 8'($urandom));
					1: run_item(ReqUndef, $urandom, 8'($urandom));
					default: run_item(ReqRestart, $urandom, 8'($urandom));
				endcase
			end
			run_item(ReqPayload, $urandom, 8'($urandom));
		end
	endtask

	// ------------------------------------------------------------------
	// output side: ready with random stalls, one long hold on request
	// ------------------------------------------------------------------
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// output check against the oldest expected byte
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (framed_q.size() == 0) begin
				$error("output byte %h with nothing expected", m_tdata[7:0]);
				fails++;
			end else begin
				want = framed_q.pop_front();
				if (m_tdata[7:0] != want.out_byte) begin
					$error("out_byte: expected %h, got %h", want.out_byte, m_tdata[7:0]);
					fails++;
				end
				if (m_tuser[0] != want.is_header) begin
					$error("is_header: expected %b, got %b", want.is_header, m_tuser[0]);
					fails++;
				end
				if (m_tdata[8] != want.message_end) begin
					$error("message_end: expected %b, got %b", want.message_end, m_tdata[8]);
					fails++;
				end
				if (m_tlast != want.run_last) begin
					$error("run_last: expected %b, got %b", want.run_last, m_tlast);
					fails++;
				end
				if (m_tdata[9] != want.error) begin
					$error("error: expected %b, got %b", want.error, m_tdata[9]);
					fails++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WatchdogLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		stim_t       row;
		logic [23:0] phase_limits [NumPhases];
		logic [23:0] limit;
		logic [31:0] len;
		int          phase_start;

		// zero entry picks a random small limit
		phase_limits = '{24'd1, 24'd2, 24'd3, 24'd7, 24'd0, 24'hFFFFFF};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stimulus table
		for (int r = 0; r < NumDirected; r++) begin
			row = directed_tab[r];
			if (row.cfg) begin
				write_chunk_limit(row.mlen[23:0]);
			end else begin
				run_item(row.req, row.mlen, row.pb);
				if (row.chk)
					framed_q[framed_q.size() - 1] = row.last;
			end
		end

		// random messages under each chunk limit; last phase runs without idling
		for (int p = 0; p < NumPhases; p++) begin
			quiet = (p == NumPhases - 1);
			limit = phase_limits[p];
			if (limit == 24'd0)
				limit = 24'($urandom_range(4, 20));
			write_chunk_limit(limit);
			if (p == 0)
				hold_req = 1'b1;
			phase_start = item_cnt;
			while (item_cnt - phase_start < PhaseItems) begin
				// noise between messages
				if ($urandom_range(0, 5) == 0) begin
					case ($urandom_range(0, 2))
						0: run_item(ReqPayload, $urandom, 8'($urandom));
						1: run_item(ReqUndef, $urandom, 8'($urandom));
						default: run_item(ReqRestart, $urandom, 8'($urandom));
					endcase
				end
				case ($urandom_range(0, 7))
					0: len = 32'd0;
					1, 2: len = (limit <= 24'd13) ? limit * $urandom_range(1, 3)
						: 32'($urandom_range(1, 40));
					default: len = (limit <= 24'd13) ? $urandom_range(1, limit * 3 + 2)
						: 32'($urandom_range(1, 40));
				endcase
				send_message(len);
			end
		end

		// longest body: header carries the full 24-bit limit, message stays open
		run_item(ReqBegin, 32'hFFFFFFFF, 8'h00);
		repeat (5) run_item(ReqPayload, $urandom, 8'($urandom));
		run_item(ReqBegin, 32'd0, 8'h00);
		s_tvalid <= 1'b0;

		while (framed_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
